[rtl/ssp_pkg.sv]
// Shared types, constants and step functions of the sprite screen projector.
`default_nettype none

package ssp_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;
   localparam int PIPE_STAGES      = 39;

   localparam logic [14:0] HALF_FOV_RST      = 15'd4289;
   localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1024;
   localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd768;

   localparam logic signed [18:0] PI_Q13      = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [31:0] ROUND_Q15   = 32'sd16384;

   localparam logic signed [15:0] COL_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] COL_MIN  = 16'sh8000;
   localparam logic [15:0]        SIZE_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_HALF_FOV      = 2'd0,
      CSR_SCREEN_WIDTH  = 2'd1,
      CSR_SCREEN_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [31:0] z;
   } cordic_type;

   typedef struct packed {
      logic [33:0] v;
      logic [34:0] r;
   } sqrt_type;

   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [15:0] view;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] pl_x;
      logic signed [15:0] pl_y;
      logic signed [32:0] pa;
      logic signed [32:0] pb;
      logic signed [32:0] pc;
      logic signed [32:0] pd;
      logic [32:0]        sqx;
      logic [32:0]        sqy;
      logic signed [34:0] den;
      logic signed [35:0] nd;
      logic               origin;
      cordic_type         cor;
      sqrt_type           sq;
      logic [46:0]        top_mag;
      logic [33:0]        den_mag;
      logic               col_neg;
      logic               den_zero;
      logic               top_nonneg;
      logic               c_ovf;
      logic [46:0]        crem;
      logic [15:0]        cq;
      logic signed [15:0] col;
      logic [16:0]        sdist;
      logic [19:0]        hrem;
      logic [19:0]        wrem;
      logic [15:0]        hq;
      logic [15:0]        wq;
      logic               h_sat;
      logic               w_sat;
      logic               visible;
      logic [16:0]        o_dist;
      logic signed [15:0] o_col;
      logic [15:0]        o_ph;
      logic [15:0]        o_pw;
   } pipe_type;

   // atan(2^-i) in radians Q3.28
   function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
      logic signed [31:0] a;
      case (i)
         5'd0:    a = 32'sd210828714;
         5'd1:    a = 32'sd124459457;
         5'd2:    a = 32'sd65760959;
         5'd3:    a = 32'sd33381290;
         5'd4:    a = 32'sd16755422;
         5'd5:    a = 32'sd8385879;
         5'd6:    a = 32'sd4193963;
         5'd7:    a = 32'sd2097109;
         5'd8:    a = 32'sd1048571;
         5'd9:    a = 32'sd524287;
         5'd10:   a = 32'sd262144;
         5'd11:   a = 32'sd131072;
         5'd12:   a = 32'sd65536;
         5'd13:   a = 32'sd32768;
         5'd14:   a = 32'sd16384;
         5'd15:   a = 32'sd8192;
         5'd16:   a = 32'sd4096;
         5'd17:   a = 32'sd2048;
         5'd18:   a = 32'sd1024;
         5'd19:   a = 32'sd512;
         5'd20:   a = 32'sd256;
         5'd21:   a = 32'sd128;
         5'd22:   a = 32'sd64;
         5'd23:   a = 32'sd32;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

   // one vectoring rotation, drives y toward zero
   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type n;
      if (c.y >= 0) begin
         n.x = c.x + (c.y >>> i);
         n.y = c.y - (c.x >>> i);
         n.z = c.z + atan_q28(5'(i));
      end else begin
         n.x = c.x - (c.y >>> i);
         n.y = c.y + (c.x >>> i);
         n.z = c.z - atan_q28(5'(i));
      end
      return n;
   endfunction

   // one restoring square root digit, trial bit 4^bp
   function automatic sqrt_type sqrt_step(input sqrt_type s, input int bp);
      sqrt_type   n;
      logic [34:0] trial;
      trial = s.r + (35'd1 << (2 * bp));
      if ({1'b0, s.v} >= trial) begin
         n.v = 34'({1'b0, s.v} - trial);
         n.r = (s.r >> 1) + (35'd1 << (2 * bp));
      end else begin
         n.v = s.v;
         n.r = s.r >> 1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/ssp_if.sv]
// Channel interfaces: sprite requests, projection responses, register writes.
`default_nettype none

interface ssp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sprite_pos_x;
   logic signed [15:0] sprite_pos_y;
   logic signed [15:0] viewer_pos_x;
   logic signed [15:0] viewer_pos_y;
   logic signed [15:0] view_angle;
   logic signed [15:0] direction_x;
   logic signed [15:0] direction_y;
   logic signed [15:0] camera_plane_x;
   logic signed [15:0] camera_plane_y;

   modport source (output valid, sprite_pos_x, sprite_pos_y, viewer_pos_x, viewer_pos_y,
                   view_angle, direction_x, direction_y, camera_plane_x, camera_plane_y,
                   input ready);
   modport sink (input valid, sprite_pos_x, sprite_pos_y, viewer_pos_x, viewer_pos_y,
                 view_angle, direction_x, direction_y, camera_plane_x, camera_plane_y,
                 output ready);
endinterface

interface ssp_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic [16:0]        sprite_distance;
   logic signed [15:0] screen_column;
   logic [15:0]        projected_height;
   logic [15:0]        projected_width;

   modport source (output valid, visible, sprite_distance, screen_column,
                   projected_height, projected_width, input ready);
   modport sink (input valid, visible, sprite_distance, screen_column,
                 projected_height, projected_width, output ready);
endinterface

interface ssp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/sprite_screen_projection.sv]
// Sprite projector top level: bearing CORDIC, sqrt, column and size dividers in one pipeline.
// Throughput: one sprite per cycle while rsp_ch is ready; a 39-stage register pipeline
// with one CORDIC rotation, one sqrt digit or one quotient bit per stage sets the depth.
// Back pressure freezes every stage at once, so a stall neither drops nor repeats.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
`default_nettype none

module sprite_screen_projection #(
   parameter int CORDIC_STEPS = ssp_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ssp_req_if.sink   req_ch,
   ssp_rsp_if.source rsp_ch,
   ssp_csr_if.sink   csr_ch
);
   import ssp_pkg::*;

   // rotations actually run; never more than the atan table holds
   localparam int NSTEP = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : CORDIC_STEPS;

   // stage map
   localparam int S_MUL  = 1;             // products and squares
   localparam int S_SUM  = 2;             // num+den, x^2+y^2, quadrant fold
   localparam int S_ITER = 3;             // first CORDIC / sqrt step, top product
   localparam int S_ANG  = S_ITER + NSTEP; // round bearing, wrap, cull
   localparam int S_CDV  = 4;             // column divide overflow check
   localparam int S_RND  = 20;            // sqrt rounding (last column bit too)
   localparam int S_SDV  = 21;            // size divide overflow, column saturate
   localparam int S_OUT  = PIPE_STAGES - 1;

   logic [14:0] half_fov_ff, half_fov_in;
   logic [11:0] screen_width_ff, screen_width_in;
   logic [11:0] screen_height_ff, screen_height_in;

   pipe_type               st_ff [PIPE_STAGES];
   pipe_type               st_in [PIPE_STAGES];
   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic                   advance;

   // everything moves together unless the output register holds an untaken response
   assign advance      = !vld_ff[S_OUT] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------------------------
   // register file
   // ---------------------------------------------------------------------------------
   always_comb begin
      half_fov_in      = half_fov_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_HALF_FOV:      half_fov_in      = csr_ch.data[14:0];
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_ch.data[11:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_ch.data[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_fov_ff      <= HALF_FOV_RST;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
      end else begin
         half_fov_ff      <= half_fov_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // work done between stage k-1 and stage k
   // ---------------------------------------------------------------------------------
   function automatic pipe_type stage_next(input pipe_type s, input int k,
                                           input logic [10:0] half, input logic [11:0] sh,
                                           input logic [11:0] sw, input logic [14:0] hfov);
      pipe_type           t;
      logic signed [47:0] top;
      logic signed [27:0] x0;
      logic signed [27:0] y0;
      logic signed [16:0] zq;
      logic signed [18:0] diff;
      logic [50:0]        dsh;
      logic [32:0]        ssh;
      t = s;

      if (k == S_MUL) begin
         t.pa  = 33'(s.dir_y) * 33'(s.dx);
         t.pb  = 33'(s.dir_x) * 33'(s.dy);
         t.pc  = 33'(s.pl_x) * 33'(s.dy);
         t.pd  = 33'(s.pl_y) * 33'(s.dx);
         t.sqx = 33'(34'(s.dx) * 34'(s.dx));
         t.sqy = 33'(34'(s.dy) * 34'(s.dy));
      end

      if (k == S_SUM) begin
         t.den    = 35'(s.pc) - 35'(s.pd);
         t.nd     = 36'(s.pa) - 36'(s.pb) + 36'(s.pc) - 36'(s.pd);
         t.sq.v   = 34'(s.sqx) + 34'(s.sqy);
         t.sq.r   = '0;
         t.origin = (s.dx == 17'sd0) && (s.dy == 17'sd0);
         // fold the left half plane onto the right one
         x0 = 28'(s.dx) <<< 8;
         y0 = 28'(s.dy) <<< 8;
         t.cor.x = x0;
         t.cor.y = y0;
         t.cor.z = '0;
         if (x0 < 0) begin
            if (y0 >= 0) begin
               t.cor.x = y0;
               t.cor.y = -x0;
               t.cor.z = HALF_PI_Q28;
            end else begin
               t.cor.x = -y0;
               t.cor.y = x0;
               t.cor.z = -HALF_PI_Q28;
            end
         end
      end

      if (k >= S_ITER && k < S_ITER + NSTEP) begin
         t.cor = cordic_step(s.cor, k - S_ITER);
      end

      if (k >= S_ITER && k < S_ITER + 17) begin
         t.sq = sqrt_step(s.sq, 16 - (k - S_ITER));
      end

      if (k == S_ITER) begin
         top          = 48'($signed({1'b0, half})) * 48'(s.nd);
         t.top_mag    = 47'((top < 0) ? -top : top);
         t.den_mag    = 34'((s.den < 0) ? -s.den : s.den);
         t.col_neg    = top[47] ^ s.den[34];
         t.top_nonneg = !top[47];
         t.den_zero   = (s.den == 35'sd0);
      end

      if (k == S_ANG) begin
         zq   = s.origin ? 17'sd0 : 17'((s.cor.z + ROUND_Q15) >>> 15);
         diff = 19'(zq) - 19'(s.view);
         if (diff > PI_Q13) diff = diff - TWO_PI_Q13;
         if (diff < -PI_Q13) diff = diff + TWO_PI_Q13;
         if (diff < 0) diff = -diff;
         t.visible = (diff[17:0] <= 18'(hfov));
      end

      // column: |top| / |den|, quotient bits MSB first
      if (k == S_CDV) begin
         t.c_ovf = ({4'd0, s.top_mag} >= {1'b0, s.den_mag, 16'd0});
         t.crem  = s.top_mag;
         t.cq    = '0;
      end
      if (k > S_CDV && k <= S_CDV + 16) begin
         dsh = 51'(s.den_mag) << (S_CDV + 16 - k);
         if (51'(s.crem) >= dsh) begin
            t.crem = 47'(51'(s.crem) - dsh);
            t.cq   = {s.cq[14:0], 1'b1};
         end else begin
            t.cq   = {s.cq[14:0], 1'b0};
         end
      end

      if (k == S_RND) begin
         t.sdist = 17'((35'(s.sq.v) > s.sq.r) ? s.sq.r + 35'd1 : s.sq.r);
      end

      if (k == S_SDV) begin
         if (s.den_zero) begin
            t.col = s.top_nonneg ? COL_MAX : COL_MIN;
         end else if (s.col_neg) begin
            t.col = (s.c_ovf || s.cq > 16'd32768) ? COL_MIN : 16'(17'd0 - 17'(s.cq));
         end else begin
            t.col = (s.c_ovf || s.cq[15]) ? COL_MAX : s.cq;
         end
         // zero distance saturates along with quotient overflow
         t.hrem  = {sh, 8'd0};
         t.wrem  = {sw, 8'd0};
         t.h_sat = (s.sdist == 17'd0) || ({13'd0, sh, 8'd0} >= {s.sdist, 16'd0});
         t.w_sat = (s.sdist == 17'd0) || ({13'd0, sw, 8'd0} >= {s.sdist, 16'd0});
         t.hq    = '0;
         t.wq    = '0;
      end
      if (k > S_SDV && k <= S_SDV + 16) begin
         ssh = 33'(s.sdist) << (S_SDV + 16 - k);
         if (33'(s.hrem) >= ssh) begin
            t.hrem = 20'(33'(s.hrem) - ssh);
            t.hq   = {s.hq[14:0], 1'b1};
         end else begin
            t.hq   = {s.hq[14:0], 1'b0};
         end
         if (33'(s.wrem) >= ssh) begin
            t.wrem = 20'(33'(s.wrem) - ssh);
            t.wq   = {s.wq[14:0], 1'b1};
         end else begin
            t.wq   = {s.wq[14:0], 1'b0};
         end
      end

      // culled sprites report all zero
      if (k == S_OUT) begin
         t.o_dist = s.visible ? s.sdist : '0;
         t.o_col  = s.visible ? s.col : '0;
         t.o_ph   = !s.visible ? '0 : (s.h_sat ? SIZE_MAX : s.hq);
         t.o_pw   = !s.visible ? '0 : (s.w_sat ? SIZE_MAX : s.wq);
      end
      return t;
   endfunction

   // ---------------------------------------------------------------------------------
   // pipeline
   // ---------------------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         st_in[k] = st_ff[k];
      end
      vld_in = vld_ff;
      if (advance) begin
         vld_in[0]         = req_ch.valid;
         st_in[0]          = st_ff[0];
         st_in[0].dx       = 17'(req_ch.sprite_pos_x) - 17'(req_ch.viewer_pos_x);
         st_in[0].dy       = 17'(req_ch.sprite_pos_y) - 17'(req_ch.viewer_pos_y);
         st_in[0].view     = req_ch.view_angle;
         st_in[0].dir_x    = req_ch.direction_x;
         st_in[0].dir_y    = req_ch.direction_y;
         st_in[0].pl_x     = req_ch.camera_plane_x;
         st_in[0].pl_y     = req_ch.camera_plane_y;
         for (int k = 1; k < PIPE_STAGES; k++) begin
            vld_in[k] = vld_ff[k-1];
            st_in[k]  = stage_next(st_ff[k-1], k, screen_width_ff[11:1], screen_height_ff,
                                   screen_width_ff, half_fov_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   // the last stage is the output register
   assign rsp_ch.valid            = vld_ff[S_OUT];
   assign rsp_ch.visible          = st_ff[S_OUT].visible;
   assign rsp_ch.sprite_distance  = st_ff[S_OUT].o_dist;
   assign rsp_ch.screen_column    = st_ff[S_OUT].o_col;
   assign rsp_ch.projected_height = st_ff[S_OUT].o_ph;
   assign rsp_ch.projected_width  = st_ff[S_OUT].o_pw;

endmodule

`default_nettype wire

[rtl/ssp_checker.sv]
// Port-level checks on the sprite projector's response channel, bound to the top level.
`default_nettype none

module ssp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               visible,
   input logic [16:0]        sprite_distance,
   input logic signed [15:0] screen_column,
   input logic [15:0]        projected_height,
   input logic [15:0]        projected_width
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({visible, sprite_distance, screen_column,
                                           projected_height, projected_width}))
      else $error("response changed while stalled");

   a_culled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !visible |-> sprite_distance == 17'd0 && screen_column == 16'sd0 &&
                                projected_height == 16'd0 && projected_width == 16'd0)
      else $error("culled sprite with nonzero fields");

   a_zero_dist_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && visible && sprite_distance == 17'd0 |->
         projected_height == 16'hFFFF && projected_width == 16'hFFFF)
      else $error("zero distance did not saturate sizes");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sprite_screen_projection ssp_checker u_ssp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .visible          (rsp_ch.visible),
   .sprite_distance  (rsp_ch.sprite_distance),
   .screen_column    (rsp_ch.screen_column),
   .projected_height (rsp_ch.projected_height),
   .projected_width  (rsp_ch.projected_width)
);

`default_nettype wire
